### hdl/gcrsd_pkg.sv
// ----------------------------------------------------------------------------
// gcrsd_pkg
// shared types, sizes and the 6-and-2 translation table for the sector decoder
// ----------------------------------------------------------------------------
`default_nettype none

package gcrsd_pkg;

    localparam int FRAGMENT_ENTRIES = 86;
    localparam int SECTOR_BYTES     = 256;
    localparam int ENCODED_BYTES    = FRAGMENT_ENTRIES + SECTOR_BYTES;
    localparam int PAIR_TWO_START   = 2 * FRAGMENT_ENTRIES;
    localparam int COUNT_W          = $clog2(ENCODED_BYTES + 2);
    localparam int FRAG_AW          = $clog2(FRAGMENT_ENTRIES);
    localparam int POS_W            = $clog2(SECTOR_BYTES);
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_SHORT    = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one queue entry: an aligned disk byte and/or a short-sector end
    typedef struct packed {
        logic               disk_vld;
        logic [7:0]         disk;
        logic [COUNT_W-1:0] idx;
        logic               short_end;
    } t_qent;

    // returns {ok, value}; value is zero for a byte outside the code set
    function automatic logic [6:0] gcr_decode(input logic [7:0] b);
        logic [6:0] r;
        unique case (b)
            8'h96: r = {1'b1, 6'd0};   8'h97: r = {1'b1, 6'd1};
            8'h9A: r = {1'b1, 6'd2};   8'h9B: r = {1'b1, 6'd3};
            8'h9D: r = {1'b1, 6'd4};   8'h9E: r = {1'b1, 6'd5};
            8'h9F: r = {1'b1, 6'd6};   8'hA6: r = {1'b1, 6'd7};
            8'hA7: r = {1'b1, 6'd8};   8'hAB: r = {1'b1, 6'd9};
            8'hAC: r = {1'b1, 6'd10};  8'hAD: r = {1'b1, 6'd11};
            8'hAE: r = {1'b1, 6'd12};  8'hAF: r = {1'b1, 6'd13};
            8'hB2: r = {1'b1, 6'd14};  8'hB3: r = {1'b1, 6'd15};
            8'hB4: r = {1'b1, 6'd16};  8'hB5: r = {1'b1, 6'd17};
            8'hB6: r = {1'b1, 6'd18};  8'hB7: r = {1'b1, 6'd19};
            8'hB9: r = {1'b1, 6'd20};  8'hBA: r = {1'b1, 6'd21};
            8'hBB: r = {1'b1, 6'd22};  8'hBC: r = {1'b1, 6'd23};
            8'hBD: r = {1'b1, 6'd24};  8'hBE: r = {1'b1, 6'd25};
            8'hBF: r = {1'b1, 6'd26};  8'hCB: r = {1'b1, 6'd27};
            8'hCD: r = {1'b1, 6'd28};  8'hCE: r = {1'b1, 6'd29};
            8'hCF: r = {1'b1, 6'd30};  8'hD3: r = {1'b1, 6'd31};
            8'hD6: r = {1'b1, 6'd32};  8'hD7: r = {1'b1, 6'd33};
            8'hD9: r = {1'b1, 6'd34};  8'hDA: r = {1'b1, 6'd35};
            8'hDB: r = {1'b1, 6'd36};  8'hDC: r = {1'b1, 6'd37};
            8'hDD: r = {1'b1, 6'd38};  8'hDE: r = {1'b1, 6'd39};
            8'hDF: r = {1'b1, 6'd40};  8'hE5: r = {1'b1, 6'd41};
            8'hE6: r = {1'b1, 6'd42};  8'hE7: r = {1'b1, 6'd43};
            8'hE9: r = {1'b1, 6'd44};  8'hEA: r = {1'b1, 6'd45};
            8'hEB: r = {1'b1, 6'd46};  8'hEC: r = {1'b1, 6'd47};
            8'hED: r = {1'b1, 6'd48};  8'hEE: r = {1'b1, 6'd49};
            8'hEF: r = {1'b1, 6'd50};  8'hF2: r = {1'b1, 6'd51};
            8'hF3: r = {1'b1, 6'd52};  8'hF4: r = {1'b1, 6'd53};
            8'hF5: r = {1'b1, 6'd54};  8'hF6: r = {1'b1, 6'd55};
            8'hF7: r = {1'b1, 6'd56};  8'hF9: r = {1'b1, 6'd57};
            8'hFA: r = {1'b1, 6'd58};  8'hFB: r = {1'b1, 6'd59};
            8'hFC: r = {1'b1, 6'd60};  8'hFD: r = {1'b1, 6'd61};
            8'hFE: r = {1'b1, 6'd62};  8'hFF: r = {1'b1, 6'd63};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/gcrsd_front.sv
// ----------------------------------------------------------------------------
// gcrsd_front
// bit aligner: turns raw bytes into disk bytes, counts them, spots sector end
// ----------------------------------------------------------------------------
`default_nettype none

module gcrsd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_raw,
    input  wire logic                 i_first,
    input  wire logic                 i_last,
    input  wire logic                 i_q_full,
    output logic                      o_ready,
    output logic                      o_push,
    output gcrsd_pkg::t_qent          o_entry
);

    logic [6:0]                      r_align;
    logic [gcrsd_pkg::COUNT_W-1:0]   r_count;
    logic                            r_done;
    logic [6:0]                      n_align;
    logic [gcrsd_pkg::COUNT_W-1:0]   n_count;
    logic                            n_done;

    logic [6:0]                      eff_align;
    logic [gcrsd_pkg::COUNT_W-1:0]   eff_count;
    logic                            eff_done;
    logic [15:0]                     w;
    logic                            close;
    logic [7:0]                      disk;
    logic [6:0]                      rem;
    logic                            do_disk;
    logic                            done_disk;
    logic                            short_end;
    logic                            accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        eff_align = i_first ? 7'd0 : r_align;
        eff_count = i_first ? '0 : r_count;
        eff_done  = i_first ? 1'b0 : r_done;
        w         = {1'b0, eff_align, i_raw};
        close     = 1'b0;
        disk      = 8'd0;
        rem       = i_raw[6:0];
        // downward so the earliest closing shift wins
        for (int j = 8; j >= 1; j--) begin
            if (w[15-j]) begin
                close = 1'b1;
                disk  = w[15-j -: 8];
                rem   = 7'(i_raw & (8'hFF >> j));
            end
        end
        do_disk   = close && !eff_done;
        done_disk = do_disk && (eff_count == gcrsd_pkg::COUNT_W'(gcrsd_pkg::ENCODED_BYTES));
        short_end = i_last && !eff_done && !done_disk;
        n_align   = rem;
        n_count   = do_disk ? eff_count + 1'b1 : eff_count;
        n_done    = eff_done || done_disk || short_end;

        o_push             = accept && (do_disk || short_end);
        o_entry.disk_vld   = do_disk;
        o_entry.disk       = disk;
        o_entry.idx        = eff_count;
        o_entry.short_end  = short_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= 7'd0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (accept) begin
            r_align <= n_align;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

`ifndef NO_ASSERTIONS
    // a finished sector ignores items until the next sector start
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_done && !i_first) |=> (r_done && $stable(r_count)))
        else $error("finished sector advanced without sector start");
`endif

endmodule

`default_nettype wire

### hdl/gcrsd_queue.sv
// ----------------------------------------------------------------------------
// gcrsd_queue
// small fifo between the aligner and the decode back end
// ----------------------------------------------------------------------------
`default_nettype none

module gcrsd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire gcrsd_pkg::t_qent     i_wdata,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output gcrsd_pkg::t_qent          o_rdata
);

    localparam int AW = $clog2(gcrsd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(gcrsd_pkg::QUEUE_DEPTH + 1);

    gcrsd_pkg::t_qent r_mem [gcrsd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(gcrsd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue underflow");
`endif

endmodule

`default_nettype wire

### hdl/gcrsd_back.sv
// ----------------------------------------------------------------------------
// gcrsd_back
// table lookup, checksum chain, fragment store and result output register
// ----------------------------------------------------------------------------
`default_nettype none

module gcrsd_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire gcrsd_pkg::t_qent     i_q_entry,
    output logic                      o_q_pop,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [23:0]               o_m_tdata,
    output logic                      o_m_tuser,
    output logic                      o_m_tlast
);

    localparam int PW = gcrsd_pkg::POS_W;
    localparam int AW = gcrsd_pkg::FRAG_AW;

    logic [5:0]    r_mem [gcrsd_pkg::FRAGMENT_ENTRIES];
    logic [5:0]    r_rd;
    logic [5:0]    r_sum;
    logic          r_dp;
    logic          r_sp;
    logic [5:0]    r_b_sum;
    logic [1:0]    r_b_pair;
    logic [PW-1:0] r_b_pos;
    logic [1:0]    r_b_status;

    logic [6:0]    lk;
    logic [5:0]    sum_cur;
    logic [5:0]    sum_new;
    logic          is_frag;
    logic          is_data;
    logic          is_chk;
    logic [1:0]    chk_status;
    logic [PW-1:0] pos;
    logic [1:0]    pair;
    logic [PW-1:0] pair_base;
    logic [AW-1:0] rd_addr;
    logic          take;
    logic          b_free;
    logic          adv;
    logic          frag_lo;
    logic          frag_hi;

    always_comb begin
        lk      = gcrsd_pkg::gcr_decode(i_q_entry.disk);
        sum_cur = (i_q_entry.idx == '0) ? 6'd0 : r_sum;
        sum_new = sum_cur ^ lk[5:0];
        is_frag = i_q_entry.disk_vld &&
                  (i_q_entry.idx < gcrsd_pkg::COUNT_W'(gcrsd_pkg::FRAGMENT_ENTRIES));
        is_chk  = i_q_entry.disk_vld &&
                  (i_q_entry.idx == gcrsd_pkg::COUNT_W'(gcrsd_pkg::ENCODED_BYTES));
        is_data = i_q_entry.disk_vld && !is_frag && !is_chk;
        chk_status = (lk[6] && (lk[5:0] == sum_cur)) ? gcrsd_pkg::STAT_OK
                                                     : gcrsd_pkg::STAT_MISMATCH;
        pos = PW'(i_q_entry.idx - gcrsd_pkg::COUNT_W'(gcrsd_pkg::FRAGMENT_ENTRIES));
        // which bit pair of the fragment word, and the word's address
        if (pos < PW'(gcrsd_pkg::FRAGMENT_ENTRIES)) begin
            pair      = 2'd0;
            pair_base = '0;
        end else if (pos < PW'(gcrsd_pkg::PAIR_TWO_START)) begin
            pair      = 2'd1;
            pair_base = PW'(gcrsd_pkg::FRAGMENT_ENTRIES);
        end else begin
            pair      = 2'd2;
            pair_base = PW'(gcrsd_pkg::PAIR_TWO_START);
        end
        rd_addr = AW'(pos - pair_base);
    end

    assign o_m_tvalid = r_dp || r_sp;
    assign take       = o_m_tvalid && i_m_tready;
    assign b_free     = !o_m_tvalid || (take && !(r_dp && r_sp));
    assign adv        = i_q_valid && b_free;
    assign o_q_pop    = adv;

    always_ff @(posedge i_clk) begin
        if (adv && is_frag) begin
            r_mem[i_q_entry.idx[AW-1:0]] <= sum_new;
        end
        if (adv && is_data) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 6'd0;
            r_dp  <= 1'b0;
            r_sp  <= 1'b0;
        end else begin
            if (adv && i_q_entry.disk_vld && !is_chk) begin
                r_sum <= sum_new;
            end
            if (adv) begin
                r_dp <= is_data;
                r_sp <= is_chk || i_q_entry.short_end;
            end else if (take) begin
                if (r_dp) begin
                    r_dp <= 1'b0;
                end else begin
                    r_sp <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_sum    <= sum_new;
            r_b_pair   <= pair;
            r_b_pos    <= pos;
            r_b_status <= is_chk ? chk_status : gcrsd_pkg::STAT_SHORT;
        end
    end

    // fragment bit pair is used swapped
    always_comb begin
        case (r_b_pair)
            2'd0:    begin frag_lo = r_rd[0]; frag_hi = r_rd[1]; end
            2'd1:    begin frag_lo = r_rd[2]; frag_hi = r_rd[3]; end
            default: begin frag_lo = r_rd[4]; frag_hi = r_rd[5]; end
        endcase
        if (r_dp) begin
            o_m_tuser = gcrsd_pkg::KIND_DATA;
            o_m_tlast = 1'b0;
            o_m_tdata = {6'd0, gcrsd_pkg::STAT_OK, r_b_pos, r_b_sum, frag_lo, frag_hi};
        end else begin
            o_m_tuser = gcrsd_pkg::KIND_STATUS;
            o_m_tlast = 1'b1;
            o_m_tdata = {6'd0, r_b_status, 16'd0};
        end
    end

`ifndef NO_ASSERTIONS
    // a status sharing an entry with a data byte follows it directly
    a_status_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_dp && r_sp) |=> (o_m_tvalid && o_m_tuser == gcrsd_pkg::KIND_STATUS))
        else $error("status result lost after data result");
    // a status item carries one of the defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp && !r_dp) |-> (r_b_status != 2'd3))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

### hdl/gcr_6and2_sector_decode.sv
// ----------------------------------------------------------------------------
// gcr_6and2_sector_decode
// 6-and-2 group-coded sector data-field decoder, stream in and stream out
// ----------------------------------------------------------------------------
// Takes one raw read byte per cycle (msb first) and realigns it into disk
// bytes; each disk byte is translated, chained into the 6-bit checksum and
// either kept as a fragment word (first 86) or turned into a data item with
// its position (next 256). The 343rd disk byte yields the status item; a tlast
// on the input before that ends the sector with the short status. tuser on the
// input starts a new sector. The aligner accepts one raw byte every cycle while
// its 4-entry queue has room; the back end retires one queue entry per cycle,
// holding the queue while a data item and a status item from one raw byte wait
// to leave, and otherwise only stalls on the output tready. Between a raw byte
// and its data item lie the queue and the result output register; the fragment
// store is a single-port memory with registered read.
`default_nettype none

module gcr_6and2_sector_decode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // raw_byte
    input  wire logic        i_s_tuser,   // first_byte
    input  wire logic        i_s_tlast,   // last_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // data[7:0], position[15:8], status[17:16]
    output logic             o_m_tuser,   // kind
    output logic             o_m_tlast    // end_mark
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    gcrsd_pkg::t_qent q_wdata;
    gcrsd_pkg::t_qent q_rdata;

    gcrsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_raw    (i_s_tdata),
        .i_first  (i_s_tuser),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (q_push),
        .o_entry  (q_wdata)
    );

    gcrsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    gcrsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_rdata),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
